>>> rtl/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants for the sprite attribute builder.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int CURSOR_W          = 8;
    localparam int SLOT_W            = 7;
    localparam int ATTR_W            = 16;

    // Hidden slots park their sprite below the visible area.
    localparam logic [ATTR_W-1:0] HIDE_ATTR0 = 16'd236;
    localparam logic [ATTR_W-1:0] HIDE_ATTR1 = 16'd0;

    typedef enum logic [1:0] {
        REQ_START    = 2'd0,
        REQ_TEMPLATE = 2'd1,
        REQ_FINISH   = 2'd2,
        REQ_READ     = 2'd3
    } sab_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_HIDE
    } sab_state_t;

    typedef struct packed {
        logic accept;
        logic load_read;
        logic walk_step;
    } sab_cmd_t;

    typedef struct packed {
        logic hide_needed;
        logic walk_last;
    } sab_stat_t;

endpackage

>>> rtl/sprite_attribute_builder.sv
// ----------------------------------------------------------------------------
// sprite_attribute_builder
// Builds and holds a shadow table of sprite attribute slots.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   request type, header, biases, template
//   m_        out        m_valid / m_ready   slot, three attributes, status, count
//
// Start, template and finish beats are taken one per cycle while the sink keeps
// up; the result register frees on the same edge it is taken.
// A read beat passes through the read state with s_ready low, since the shadow
// table read port has registered data. A finish beat on a table that is not full
// then walks the unused slots, one slot a cycle, from the cursor to the table end with s_ready low.
// Reset clears the write cursor and the control; table contents are undefined
// until written. A stalled m_ready holds the result and stops input beats.
// ----------------------------------------------------------------------------
module sprite_attribute_builder
    import sab_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [CURSOR_W-1:0] s_start_slot,
    input  logic [ATTR_W-1:0]   s_rec_word0,
    input  logic [ATTR_W-1:0]   s_rec_word1,
    input  logic [ATTR_W-1:0]   s_x_bias,
    input  logic [ATTR_W-1:0]   s_y_bias,
    input  logic [ATTR_W-1:0]   s_tmpl_attr0,
    input  logic [ATTR_W-1:0]   s_tmpl_attr1,
    input  logic [ATTR_W-1:0]   s_tmpl_attr1_flip,
    input  logic [ATTR_W-1:0]   s_tmpl_attr2,
    input  logic [SLOT_W-1:0]   s_read_slot,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SLOT_W-1:0]   m_slot,
    output logic [ATTR_W-1:0]   m_attr0_out,
    output logic [ATTR_W-1:0]   m_attr1_out,
    output logic [ATTR_W-1:0]   m_attr2_out,
    output logic                m_written,
    output logic                m_entry_last,
    output logic                m_table_full,
    output logic [CURSOR_W-1:0] m_used_count
);

    sab_cmd_t  cmd;
    sab_stat_t stat;

    sab_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    sab_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_req_type        (s_req_type),
        .s_start_slot      (s_start_slot),
        .s_rec_word0       (s_rec_word0),
        .s_rec_word1       (s_rec_word1),
        .s_x_bias          (s_x_bias),
        .s_y_bias          (s_y_bias),
        .s_tmpl_attr0      (s_tmpl_attr0),
        .s_tmpl_attr1      (s_tmpl_attr1),
        .s_tmpl_attr1_flip (s_tmpl_attr1_flip),
        .s_tmpl_attr2      (s_tmpl_attr2),
        .s_read_slot       (s_read_slot),
        .m_slot            (m_slot),
        .m_attr0_out       (m_attr0_out),
        .m_attr1_out       (m_attr1_out),
        .m_attr2_out       (m_attr2_out),
        .m_written         (m_written),
        .m_entry_last      (m_entry_last),
        .m_table_full      (m_table_full),
        .m_used_count      (m_used_count)
    );

endmodule

>>> rtl/sab_ram.sv
// ----------------------------------------------------------------------------
// sab_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sab_datapath.sv
// ----------------------------------------------------------------------------
// sab_datapath
// Attribute arithmetic, write cursor, hide walk counter, shadow table and
// result register.
// ----------------------------------------------------------------------------
module sab_datapath
    import sab_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sab_cmd_t            cmd,
    output sab_stat_t           stat,
    input  logic [1:0]          s_req_type,
    input  logic [CURSOR_W-1:0] s_start_slot,
    input  logic [ATTR_W-1:0]   s_rec_word0,
    input  logic [ATTR_W-1:0]   s_rec_word1,
    input  logic [ATTR_W-1:0]   s_x_bias,
    input  logic [ATTR_W-1:0]   s_y_bias,
    input  logic [ATTR_W-1:0]   s_tmpl_attr0,
    input  logic [ATTR_W-1:0]   s_tmpl_attr1,
    input  logic [ATTR_W-1:0]   s_tmpl_attr1_flip,
    input  logic [ATTR_W-1:0]   s_tmpl_attr2,
    input  logic [SLOT_W-1:0]   s_read_slot,
    output logic [SLOT_W-1:0]   m_slot,
    output logic [ATTR_W-1:0]   m_attr0_out,
    output logic [ATTR_W-1:0]   m_attr1_out,
    output logic [ATTR_W-1:0]   m_attr2_out,
    output logic                m_written,
    output logic                m_entry_last,
    output logic                m_table_full,
    output logic [CURSOR_W-1:0] m_used_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [CURSOR_W-1:0] ENTRIES = CURSOR_W'(TABLE_ENTRIES);
    localparam logic [CURSOR_W-1:0] LAST    = CURSOR_W'(TABLE_ENTRIES - 1);

    function automatic logic [ATTR_W-1:0] make_attr0(input logic [ATTR_W-1:0] w0,
                                                     input logic [ATTR_W-1:0] tmpl,
                                                     input logic [ATTR_W-1:0] yb);
        logic [ATTR_W-1:0] m;
        m = tmpl | {4'b0, w0[11:10], 10'b0};
        return {m[15:8], m[7:0] + yb[7:0]};
    endfunction

    function automatic logic [ATTR_W-1:0] make_attr1(input logic [ATTR_W-1:0] w,
                                                     input logic [ATTR_W-1:0] xb);
        return {w[15:9], w[8:0] + xb[8:0]};
    endfunction

    function automatic logic [ATTR_W-1:0] make_attr2(input logic [ATTR_W-1:0] w0,
                                                     input logic [ATTR_W-1:0] w1,
                                                     input logic [ATTR_W-1:0] tmpl);
        logic [ATTR_W-1:0] v;
        logic [4:0]        nib;
        v   = tmpl;
        nib = {1'b0, v[15:12]} + {1'b0, w1[15:12]};
        if (w1[15:11] != 5'd0) begin
            if (w1[11]) begin
                // The palette step only applies when the top nibble does not wrap.
                if (!nib[4]) begin
                    v = {nib[3:0], v[11:0]};
                end
            end else begin
                v = {w1[15:12], v[11:0]};
            end
        end
        if (w0[14:13] != 2'd0) begin
            v = {v[15:12], w0[14:13], v[9:0]};
        end
        return v + {5'b0, w1[10:0]};
    endfunction

    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [CURSOR_W-1:0] walk_reg, walk_next;
    logic [SLOT_W-1:0]   rs_reg;
    logic                rs_ok_reg;

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [ATTR_W-1:0]   a0_reg, a0_next;
    logic [ATTR_W-1:0]   a1_reg, a1_next;
    logic [ATTR_W-1:0]   a2_reg, a2_next;
    logic                wr_reg, wr_next;
    logic                last_reg, last_next;
    logic                full_reg, full_next;
    logic [CURSOR_W-1:0] used_reg, used_next;

    sab_req_t            req;
    logic                tmpl_wr;
    logic                rd_en;
    logic                rs_ok;
    logic [ATTR_W-1:0]   b0, b1, b2;
    logic [IDX_W-1:0]    wr_addr;
    logic [2*ATTR_W-1:0] wr_data01;
    logic [2*ATTR_W-1:0] rd_data01;
    logic [ATTR_W-1:0]   rd_data2;

    assign req     = sab_req_t'(s_req_type);
    assign tmpl_wr = cmd.accept && (req == REQ_TEMPLATE) && stat.hide_needed;
    assign rd_en   = cmd.accept && (req == REQ_READ);
    assign rs_ok   = {1'b0, s_read_slot} < ENTRIES;

    assign stat.hide_needed = cursor_reg < ENTRIES;
    assign stat.walk_last   = walk_reg == LAST;

    assign b0 = make_attr0(s_rec_word0, s_tmpl_attr0, s_y_bias);
    assign b1 = make_attr1(s_rec_word0[15] ? s_tmpl_attr1_flip : s_tmpl_attr1, s_x_bias);
    assign b2 = make_attr2(s_rec_word0, s_rec_word1, s_tmpl_attr2);

    assign wr_addr   = cmd.walk_step ? walk_reg[IDX_W-1:0] : cursor_reg[IDX_W-1:0];
    assign wr_data01 = cmd.walk_step ? {HIDE_ATTR0, HIDE_ATTR1} : {b0, b1};

    always_comb begin
        cursor_next = cursor_reg;
        walk_next   = walk_reg;
        slot_next   = slot_reg;
        a0_next     = a0_reg;
        a1_next     = a1_reg;
        a2_next     = a2_reg;
        wr_next     = wr_reg;
        last_next   = last_reg;
        full_next   = full_reg;
        used_next   = used_reg;
        if (cmd.walk_step) begin
            walk_next = walk_reg + 1'b1;
        end
        if (cmd.accept) begin
            slot_next = '0;
            a0_next   = '0;
            a1_next   = '0;
            a2_next   = '0;
            wr_next   = 1'b0;
            last_next = 1'b0;
            used_next = '0;
            case (req)
                REQ_START: begin
                    cursor_next = (s_start_slot > ENTRIES) ? ENTRIES : s_start_slot;
                end
                REQ_TEMPLATE: begin
                    last_next = s_tmpl_attr0[12];
                    if (stat.hide_needed) begin
                        slot_next   = SLOT_W'(cursor_reg[IDX_W-1:0]);
                        a0_next     = b0;
                        a1_next     = b1;
                        a2_next     = b2;
                        wr_next     = 1'b1;
                        cursor_next = cursor_reg + 1'b1;
                    end
                end
                REQ_FINISH: begin
                    used_next = cursor_reg;
                    walk_next = cursor_reg;
                end
                REQ_READ: begin
                end
                default: begin
                end
            endcase
            full_next = cursor_next >= ENTRIES;
        end
        if (cmd.load_read) begin
            slot_next = rs_reg;
            a0_next   = rs_ok_reg ? rd_data01[2*ATTR_W-1:ATTR_W] : '0;
            a1_next   = rs_ok_reg ? rd_data01[ATTR_W-1:0] : '0;
            a2_next   = rs_ok_reg ? rd_data2 : '0;
            wr_next   = 1'b0;
            last_next = 1'b0;
            used_next = '0;
            full_next = cursor_reg >= ENTRIES;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else begin
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg <= walk_next;
        slot_reg <= slot_next;
        a0_reg   <= a0_next;
        a1_reg   <= a1_next;
        a2_reg   <= a2_next;
        wr_reg   <= wr_next;
        last_reg <= last_next;
        full_reg <= full_next;
        used_reg <= used_next;
        if (rd_en) begin
            rs_reg    <= s_read_slot;
            rs_ok_reg <= rs_ok;
        end
    end

    // attr0 and attr1 live apart from attr2 so the hide walk leaves attr2 alone.
    sab_ram #(
        .WIDTH (2*ATTR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram01 (
        .aclk    (aclk),
        .wr_en   (tmpl_wr || cmd.walk_step),
        .wr_addr (wr_addr),
        .wr_data (wr_data01),
        .rd_en   (rd_en),
        .rd_addr (s_read_slot[IDX_W-1:0]),
        .rd_data (rd_data01)
    );

    sab_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram2 (
        .aclk    (aclk),
        .wr_en   (tmpl_wr),
        .wr_addr (cursor_reg[IDX_W-1:0]),
        .wr_data (b2),
        .rd_en   (rd_en),
        .rd_addr (s_read_slot[IDX_W-1:0]),
        .rd_data (rd_data2)
    );

    assign m_slot       = slot_reg;
    assign m_attr0_out  = a0_reg;
    assign m_attr1_out  = a1_reg;
    assign m_attr2_out  = a2_reg;
    assign m_written    = wr_reg;
    assign m_entry_last = last_reg;
    assign m_table_full = full_reg;
    assign m_used_count = used_reg;

    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= ENTRIES)
        else $error("write cursor beyond table end");

    a_tmpl_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        tmpl_wr |=> cursor_reg == $past(cursor_reg) + 1'b1)
        else $error("cursor did not advance after a stored entry");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> (walk_reg >= cursor_reg) && (walk_reg < ENTRIES))
        else $error("hide walk outside the unused range");

endmodule

>>> rtl/sab_ctrl.sv
// ----------------------------------------------------------------------------
// sab_ctrl
// Sequencer for accept, read-back wait and the finish hide walk, plus the
// result valid flag.
// ----------------------------------------------------------------------------
module sab_ctrl
    import sab_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    output logic       m_valid,
    input  logic       m_ready,
    output sab_cmd_t   cmd,
    input  sab_stat_t  stat
);

    sab_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    sab_req_t   req;

    assign req      = sab_req_t'(s_req_type);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && (req == REQ_READ)) begin
                    state_next = ST_READ;
                end else if (cmd.accept && (req == REQ_FINISH) && stat.hide_needed) begin
                    state_next = ST_HIDE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HIDE: begin
                if (stat.walk_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.accept    = 1'b0;
        cmd.load_read = 1'b0;
        cmd.walk_step = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = out_free;
                cmd.accept = s_valid && out_free;
            end
            ST_READ: begin
                cmd.load_read = out_free;
            end
            ST_HIDE: begin
                cmd.walk_step = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if ((cmd.accept && (req != REQ_READ)) || cmd.load_read) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_read_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && (req == REQ_READ)) |=> (state_reg == ST_READ) && !m_valid_reg)
        else $error("read beat did not wait for table data");

    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HIDE && stat.walk_last) |=> state_reg == ST_IDLE)
        else $error("hide walk ran past table end");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.accept && !cmd.load_read)
        else $error("result register loaded while a beat is pending");

    a_finish_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && (req == REQ_FINISH) && !stat.hide_needed) |=> state_reg == ST_IDLE)
        else $error("hide walk started on a full table");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sprite attribute builder. A short stimulus table covers
// table limits, dropped entries, slot hiding and read-back. Random sprite
// frames and noise beats follow. Fixed rows carry their result; a local model
// of the shadow table predicts the rest, and all are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import sab_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int TOTAL_BEATS  = 850;

    typedef struct {
        sab_req_t    kind;
        logic [7:0]  start;
        logic [15:0] word0;
        logic [15:0] word1;
        logic [15:0] xbias;
        logic [15:0] ybias;
        logic [15:0] tattr0;
        logic [15:0] tattr1;
        logic [15:0] tattr1f;
        logic [15:0] tattr2;
        logic [6:0]  rslot;
    } sprite_req_t;

    typedef struct packed {
        logic [6:0]  slot;
        logic [15:0] attr0;
        logic [15:0] attr1;
        logic [15:0] attr2;
        logic        written;
        logic        last;
        logic        full;
        logic [7:0]  used;
    } sprite_res_t;

    typedef struct {
        sprite_req_t req;
        bit          fixed;
        sprite_res_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [7:0]  s_start_slot;
    logic [15:0] s_rec_word0;
    logic [15:0] s_rec_word1;
    logic [15:0] s_x_bias;
    logic [15:0] s_y_bias;
    logic [15:0] s_tmpl_attr0;
    logic [15:0] s_tmpl_attr1;
    logic [15:0] s_tmpl_attr1_flip;
    logic [15:0] s_tmpl_attr2;
    logic [6:0]  s_read_slot;
    logic        m_valid;
    logic        m_ready;
    logic [6:0]  m_slot;
    logic [15:0] m_attr0_out;
    logic [15:0] m_attr1_out;
    logic [15:0] m_attr2_out;
    logic        m_written;
    logic        m_entry_last;
    logic        m_table_full;
    logic [7:0]  m_used_count;

    // Model of the shadow table as the block should hold it.
    logic [15:0] shadow_attr0 [TABLE_ENTRIES_DEF];
    logic [15:0] shadow_attr1 [TABLE_ENTRIES_DEF];
    logic [15:0] shadow_attr2 [TABLE_ENTRIES_DEF];
    bit          slot_loaded  [TABLE_ENTRIES_DEF];
    logic [7:0]  cursor_model;

    sprite_res_t pending_results[$];
    stim_row_t   directed_rows[$];

    int  mismatches;
    int  beats_sent;
    int  beats_checked;
    int  n_start;
    int  n_tmpl;
    int  n_drop;
    int  n_finish;
    int  n_read;
    bit  sender_quiet;
    bit  sink_hold;

    sprite_attribute_builder dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_start_slot      (s_start_slot),
        .s_rec_word0       (s_rec_word0),
        .s_rec_word1       (s_rec_word1),
        .s_x_bias          (s_x_bias),
        .s_y_bias          (s_y_bias),
        .s_tmpl_attr0      (s_tmpl_attr0),
        .s_tmpl_attr1      (s_tmpl_attr1),
        .s_tmpl_attr1_flip (s_tmpl_attr1_flip),
        .s_tmpl_attr2      (s_tmpl_attr2),
        .s_read_slot       (s_read_slot),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_slot            (m_slot),
        .m_attr0_out       (m_attr0_out),
        .m_attr1_out       (m_attr1_out),
        .m_attr2_out       (m_attr2_out),
        .m_written         (m_written),
        .m_entry_last      (m_entry_last),
        .m_table_full      (m_table_full),
        .m_used_count      (m_used_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic sprite_req_t mk_req(sab_req_t kind, logic [7:0] start,
            logic [15:0] w0, w1, xb, yb, t0, t1, t1f, t2, logic [6:0] rs);
        sprite_req_t b;
        b.kind    = kind;
        b.start   = start;
        b.word0   = w0;
        b.word1   = w1;
        b.xbias   = xb;
        b.ybias   = yb;
        b.tattr0  = t0;
        b.tattr1  = t1;
        b.tattr1f = t1f;
        b.tattr2  = t2;
        b.rslot   = rs;
        return b;
    endfunction

    function automatic sprite_res_t mk_res(logic [6:0] slot, logic [15:0] a0, a1, a2,
            logic wr, logic last, logic full, logic [7:0] used);
        sprite_res_t r;
        r.slot    = slot;
        r.attr0   = a0;
        r.attr1   = a1;
        r.attr2   = a2;
        r.written = wr;
        r.last    = last;
        r.full    = full;
        r.used    = used;
        return r;
    endfunction

    function automatic void add_row(sprite_req_t req, bit fixed, sprite_res_t want);
        stim_row_t row;
        row.req   = req;
        row.fixed = fixed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [15:0] rand16();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic sprite_req_t random_req();
        return mk_req(sab_req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      rand16(), rand16(), rand16(), rand16(), rand16(), rand16(),
                      rand16(), rand16(), 7'($urandom_range(0, 127)));
    endfunction

    // Only slots filled by a template have all three words defined.
    function automatic logic [6:0] pick_loaded_slot();
        int rs;
        do rs = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
        while (!slot_loaded[rs]);
        return 7'(rs);
    endfunction

    // Idle cycles before the next beat; quiet stretches give back-to-back traffic.
    function automatic int idle_cycles(inout bit quiet);
        if ($urandom_range(0, 24) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // Applies one accepted beat to the table model and returns its result.
    function automatic sprite_res_t sprite_table_step(sprite_req_t b);
        sprite_res_t r;
        logic [15:0] m, w, a0, a1, pal, tile, prio, t, sum, v;
        int          k;
        r = '0;
        case (b.kind)
            REQ_START: begin
                cursor_model = (b.start > TABLE_ENTRIES_DEF) ? 8'(TABLE_ENTRIES_DEF) : b.start;
                n_start++;
            end
            REQ_TEMPLATE: begin
                r.last = b.tattr0[12];
                n_tmpl++;
                if (cursor_model < TABLE_ENTRIES_DEF) begin
                    m  = b.tattr0 | (b.word0 & 16'h0C00);
                    a0 = {m[15:8], 8'(b.ybias[7:0] + m[7:0])};
                    w  = b.word0[15] ? b.tattr1f : b.tattr1;
                    a1 = {w[15:9], 9'(b.xbias[8:0] + w[8:0])};
                    pal  = b.word1 & 16'hF800;
                    tile = b.word1 & 16'h07FF;
                    prio = (b.word0 & 16'h6000) >> 3;
                    v    = b.tattr2;
                    if (pal != 16'h0) begin
                        if (pal[11]) begin
                            // The palette offset only applies if it does not wrap past it.
                            t   = pal & 16'hF000;
                            sum = v + t;
                            if ((sum & 16'hF000) >= t)
                                v = sum;
                        end else begin
                            v = (v & 16'h0FFF) | pal;
                        end
                    end
                    if (prio != 16'h0)
                        v = (v & 16'hF3FF) | prio;
                    v = v + tile;
                    shadow_attr0[cursor_model[6:0]] = a0;
                    shadow_attr1[cursor_model[6:0]] = a1;
                    shadow_attr2[cursor_model[6:0]] = v;
                    slot_loaded[cursor_model[6:0]]  = 1'b1;
                    r.slot    = cursor_model[6:0];
                    r.attr0   = a0;
                    r.attr1   = a1;
                    r.attr2   = v;
                    r.written = 1'b1;
                    cursor_model++;
                end else begin
                    n_drop++;
                end
            end
            REQ_FINISH: begin
                for (k = cursor_model; k < TABLE_ENTRIES_DEF; k++) begin
                    shadow_attr0[k] = HIDE_ATTR0;
                    shadow_attr1[k] = HIDE_ATTR1;
                end
                r.used = cursor_model;
                n_finish++;
            end
            default: begin
                r.slot  = b.rslot;
                r.attr0 = shadow_attr0[b.rslot];
                r.attr1 = shadow_attr1[b.rslot];
                r.attr2 = shadow_attr2[b.rslot];
                n_read++;
            end
        endcase
        r.full = (cursor_model >= TABLE_ENTRIES_DEF);
        return r;
    endfunction

    // Drives one beat, waits for it to be taken, then idles for the next one.
    // s_valid is left high when no idle follows, so the next call replaces the payload.
    task automatic offer_beat(sprite_req_t b, bit fixed, sprite_res_t want);
        sprite_res_t predicted;
        int          gap;
        s_req_type        <= b.kind;
        s_start_slot      <= b.start;
        s_rec_word0       <= b.word0;
        s_rec_word1       <= b.word1;
        s_x_bias          <= b.xbias;
        s_y_bias          <= b.ybias;
        s_tmpl_attr0      <= b.tattr0;
        s_tmpl_attr1      <= b.tattr1;
        s_tmpl_attr1_flip <= b.tattr1f;
        s_tmpl_attr2      <= b.tattr2;
        s_read_slot       <= b.rslot;
        s_valid           <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = sprite_table_step(b);
        pending_results.push_back(fixed ? want : predicted);
        beats_sent++;
        gap = idle_cycles(sender_quiet);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // A frame as a feeder sends it: start, records of templates, an optional finish and read-back.
    task automatic run_frame();
        sprite_req_t b, hdr;
        int          pick, n_rec, n_tpl, n_rd, i, j;
        pick = $urandom_range(0, 9);
        b = random_req();
        b.kind = REQ_START;
        if (pick < 6)
            b.start = 8'($urandom_range(0, 24));
        else if (pick < 9)
            b.start = 8'($urandom_range(96, 128));
        else
            b.start = 8'($urandom_range(129, 255));
        offer_beat(b, 1'b0, '0);
        n_rec = $urandom_range(1, 4);
        for (i = 0; i < n_rec; i++) begin
            hdr = random_req();
            hdr.kind = REQ_TEMPLATE;
            n_tpl = $urandom_range(1, 6);
            for (j = 0; j < n_tpl; j++) begin
                b = hdr;
                b.tattr0     = rand16();
                b.tattr0[12] = (j == n_tpl - 1);
                b.tattr1     = rand16();
                b.tattr1f    = rand16();
                b.tattr2     = rand16();
                offer_beat(b, 1'b0, '0);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            b = random_req();
            b.kind = REQ_FINISH;
            offer_beat(b, 1'b0, '0);
        end
        n_rd = $urandom_range(0, 4);
        for (i = 0; i < n_rd; i++) begin
            b = random_req();
            b.kind  = REQ_READ;
            b.rslot = pick_loaded_slot();
            offer_beat(b, 1'b0, '0);
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        sprite_res_t exp_res;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result beat on slot 0x%0h with no beat outstanding", m_slot);
                mismatches++;
            end else begin
                exp_res = pending_results.pop_front();
                check_field("slot", 16'(exp_res.slot), 16'(m_slot));
                check_field("attr0_out", exp_res.attr0, m_attr0_out);
                check_field("attr1_out", exp_res.attr1, m_attr1_out);
                check_field("attr2_out", exp_res.attr2, m_attr2_out);
                check_field("written", 16'(exp_res.written), 16'(m_written));
                check_field("entry_last", 16'(exp_res.last), 16'(m_entry_last));
                check_field("table_full", 16'(exp_res.full), 16'(m_table_full));
                check_field("used_count", 16'(exp_res.used), 16'(m_used_count));
                beats_checked++;
            end
        end
    end

    initial begin : result_sink
        int stall;
        bit quiet;
        quiet   = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            if (sink_hold) begin
                // Long hold-off so the result register fills and the input stalls.
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_hold = 1'b0;
            end else begin
                stall = idle_cycles(quiet);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid === 1'b1 && m_ready === 1'b1))
                @(posedge aclk);
        end
    end

    initial begin : run_limit
        #8000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        sprite_req_t b;
        int          i, n_noise;
        bit          hold_done, pause_done;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        sender_quiet = 1'b0;
        sink_hold    = 1'b0;
        cursor_model = 8'd0;
        for (i = 0; i < TABLE_ENTRIES_DEF; i++)
            slot_loaded[i] = 1'b0;
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_req_type        <= REQ_START;
        s_start_slot      <= '0;
        s_rec_word0       <= '0;
        s_rec_word1       <= '0;
        s_x_bias          <= '0;
        s_y_bias          <= '0;
        s_tmpl_attr0      <= '0;
        s_tmpl_attr1      <= '0;
        s_tmpl_attr1_flip <= '0;
        s_tmpl_attr2      <= '0;
        s_read_slot       <= '0;

        // Limits, drops, hiding and read-back; fixed rows carry their result.
        add_row(mk_req(REQ_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_START, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 1, 0));
        add_row(mk_req(REQ_TEMPLATE, 255, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
                       'hFFFF, 'hFFFF, 'hFFFF, 127), 1, mk_res(0, 0, 0, 0, 0, 1, 1, 0));
        add_row(mk_req(REQ_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 1, 128));
        add_row(mk_req(REQ_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_TEMPLATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 1, 0, 0, 0));
        add_row(mk_req(REQ_TEMPLATE, 'hFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
                       'hFFFF, 'hFFFF, 'hFFFF, 'h7F), 0, '0);
        add_row(mk_req(REQ_TEMPLATE, 0, 'h8000, 0, 'h01FF, 0, 0, 'h1234, 'hABCD, 0, 0),
                0, '0);
        add_row(mk_req(REQ_TEMPLATE, 0, 'h6C00, 0, 0, 'h00FF, 'h00F0, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(REQ_TEMPLATE, 0, 0, 'hF800, 0, 0, 0, 0, 0, 'h2000, 0), 0, '0);
        add_row(mk_req(REQ_TEMPLATE, 0, 0, 'h1800, 0, 0, 0, 0, 0, 'h0100, 0), 0, '0);
        add_row(mk_req(REQ_TEMPLATE, 0, 0, 'hA123, 0, 0, 0, 0, 0, 'hFFFF, 0), 0, '0);
        add_row(mk_req(REQ_TEMPLATE, 0, 'h2000, 'h07FF, 0, 0, 'h1000, 0, 0, 'hFFFF, 0),
                0, '0);
        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3), 0, '0);
        add_row(mk_req(REQ_START, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 1, 0));
        add_row(mk_req(REQ_START, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_TEMPLATE, 0, 'hA5A5, 'h5A5A, 'h1234, 'h4321, 'h0F0F,
                       'hF0F0, 'h3C3C, 'hC3C3, 0), 0, '0);
        add_row(mk_req(REQ_TEMPLATE, 0, 0, 0, 0, 0, 'hEFFF, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 1, 0));
        add_row(mk_req(REQ_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 1, 128));
        add_row(mk_req(REQ_START, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_TEMPLATE, 0, 'h4400, 'h3ABC, 'h0F00, 'h00F0, 'h0FFF,
                       'h01FF, 'hFE00, 'h7777, 0), 0, '0);
        add_row(mk_req(REQ_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_res(0, 0, 0, 0, 0, 0, 0, 6));
        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 127), 0, '0);
        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5), 0, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            offer_beat(directed_rows[r].req, directed_rows[r].fixed, directed_rows[r].want);

        while (beats_sent < TOTAL_BEATS) begin
            if (!hold_done && beats_sent >= 300) begin
                sink_hold = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && beats_sent >= 550) begin
                // Let every outstanding result drain before the next beats.
                s_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge aclk);
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 6) begin
                run_frame();
            end else begin
                n_noise = $urandom_range(1, 6);
                for (i = 0; i < n_noise; i++) begin
                    b = random_req();
                    if (b.kind == REQ_READ)
                        b.rslot = pick_loaded_slot();
                    offer_beat(b, 1'b0, '0);
                end
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        // A finish on an empty table walks every slot after its result.
        repeat (200) @(posedge aclk);

        $display("Sent %0d beats: %0d start, %0d template (%0d dropped when full),",
                 beats_sent, n_start, n_tmpl, n_drop);
        $display("%0d finish, %0d read; %0d results checked with %0d mismatches.",
                 n_finish, n_read, beats_checked, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
